/* hw/rtl/four_digit_segment_display_control_core_assert.svh */
// Assertion helpers for the display control core.
// Both expect clk and rst in scope.
`ifndef FOUR_DIGIT_SEGMENT_DISPLAY_CONTROL_CORE_ASSERT_SVH
`define FOUR_DIGIT_SEGMENT_DISPLAY_CONTROL_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the trigger.
`define FDSD_ASSERT_SAME(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("fdsd: check failed in the same cycle");

// Consequent holds in the cycle after the trigger.
`define FDSD_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("fdsd: check failed one cycle later");

`endif

/* hw/rtl/fdsd_pkg.sv */
`timescale 1ns / 1ps
package fdsd_pkg;

  localparam int NumDigits  = 4;
  localparam int NumPoints  = 3;
  localparam int SegW       = 7;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam int MaxHexDigit = 15;
  localparam int MaxDecimal  = 9999;
  localparam int MaxHours    = 23;
  localparam int MaxMinutes  = 59;
  localparam int DecBase     = 10;

  // Reciprocals for exact constant division over the ranges in use
  localparam int Recip1000  = 8389;
  localparam int Shift1000  = 23;
  localparam int Recip100   = 5243;
  localparam int Shift100   = 19;
  localparam int Recip10    = 6554;
  localparam int Shift10    = 16;
  localparam int Recip10Sm  = 205;
  localparam int Shift10Sm  = 11;

  typedef enum logic [3:0] {
    OP_SET_DIGIT   = 4'd0,
    OP_BLANK_DIGIT = 4'd1,
    OP_SET_POINT   = 4'd2,
    OP_CLR_POINT   = 4'd3,
    OP_SET_COLON   = 4'd4,
    OP_CLR_COLON   = 4'd5,
    OP_HEX         = 4'd6,
    OP_DECIMAL     = 4'd7,
    OP_TIME        = 4'd8
  } op_t;

  typedef logic [SegW-1:0] seg_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] pos;
    logic [15:0] value;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [3:0] q1000;
    logic [6:0] q100;
    logic [9:0] q10;
    logic [1:0] hours_tens;
    logic [2:0] minutes_tens;
    logic       bad;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic seg_t hex_seg(input logic [3:0] nib);
    seg_t seg;
    unique case (nib)
      4'h0: seg = 7'h3F;
      4'h1: seg = 7'h06;
      4'h2: seg = 7'h5B;
      4'h3: seg = 7'h4F;
      4'h4: seg = 7'h66;
      4'h5: seg = 7'h6D;
      4'h6: seg = 7'h7D;
      4'h7: seg = 7'h07;
      4'h8: seg = 7'h7F;
      4'h9: seg = 7'h6F;
      4'hA: seg = 7'h77;
      4'hB: seg = 7'h7C;
      4'hC: seg = 7'h39;
      4'hD: seg = 7'h5E;
      4'hE: seg = 7'h79;
      4'hF: seg = 7'h71;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

/* hw/rtl/fdsd_front.sv */
`timescale 1ns / 1ps
module fdsd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  logic [3:0]      op,
  input  logic [1:0]      position,
  input  logic [15:0]     value,
  input  logic [4:0]      hours,
  input  logic [5:0]      minutes,
  input  fdsd_pkg::q_stat_t q_stat,
  output logic            push,
  output fdsd_pkg::cmd_t  push_cmd
);
  import fdsd_pkg::*;

  logic        front_valid;
  cmd_t        front_cmd;
  cmd_t        cmd_next;
  logic [13:0] dec_val;
  logic [27:0] p1000;
  logic [27:0] p100;
  logic [27:0] p10;
  logic [12:0] p_hours;
  logic [13:0] p_minutes;
  logic        bad;

  assign cmd_stall = front_valid & q_stat.full;
  assign push      = front_valid & ~q_stat.full;
  assign push_cmd  = front_cmd;

  // Classify the request and take the constant-divisor quotients
  always_comb begin
    dec_val   = value[13:0];
    p1000     = 28'(dec_val) * 28'(Recip1000);
    p100      = 28'(dec_val) * 28'(Recip100);
    p10       = 28'(dec_val) * 28'(Recip10);
    p_hours   = 13'(hours) * 13'(Recip10Sm);
    p_minutes = 14'(minutes) * 14'(Recip10Sm);

    bad = 1'b0;
    if (op > 4'(OP_TIME)) begin
      bad = 1'b1;
    end else if (op == 4'(OP_SET_DIGIT) && value > 16'(MaxHexDigit)) begin
      bad = 1'b1;
    end else if ((op == 4'(OP_SET_POINT) || op == 4'(OP_CLR_POINT)) &&
                 position == 2'(NumPoints)) begin
      bad = 1'b1;
    end else if (op == 4'(OP_DECIMAL) && value > 16'(MaxDecimal)) begin
      bad = 1'b1;
    end else if (op == 4'(OP_TIME) &&
                 (hours > 5'(MaxHours) || minutes > 6'(MaxMinutes))) begin
      bad = 1'b1;
    end

    cmd_next.op           = op_t'(op);
    cmd_next.pos          = position;
    cmd_next.value        = value;
    cmd_next.hours        = hours;
    cmd_next.minutes      = minutes;
    cmd_next.q1000        = p1000[Shift1000 +: 4];
    cmd_next.q100         = p100[Shift100 +: 7];
    cmd_next.q10          = p10[Shift10 +: 10];
    cmd_next.hours_tens   = p_hours[Shift10Sm +: 2];
    cmd_next.minutes_tens = p_minutes[Shift10Sm +: 3];
    cmd_next.bad          = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (!cmd_stall) begin
      front_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall) begin
      front_cmd <= cmd_next;
    end
  end

endmodule

/* hw/rtl/fdsd_queue.sv */
`timescale 1ns / 1ps
module fdsd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fdsd_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output fdsd_pkg::cmd_t    head,
  output fdsd_pkg::q_stat_t q_stat
);
  import fdsd_pkg::*;

  cmd_t                 entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = (count == QueueCntW'(QueueDepth));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* hw/rtl/fdsd_back.sv */
`timescale 1ns / 1ps
module fdsd_back (
  input  logic              clk,
  input  logic              rst,
  input  fdsd_pkg::cmd_t    head,
  input  fdsd_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              disp_valid,
  input  logic              disp_stall,
  output logic [6:0]        digit0_segments,
  output logic [6:0]        digit1_segments,
  output logic [6:0]        digit2_segments,
  output logic [6:0]        digit3_segments,
  output logic [2:0]        points,
  output logic              colon,
  output logic              bad_request
);
  import fdsd_pkg::*;

  seg_t                 digits      [NumDigits];
  seg_t                 digits_next [NumDigits];
  logic [NumPoints-1:0] points_next;
  logic                 colon_next;
  logic [6:0]           rem1;
  logic [9:0]           rem2;
  logic [13:0]          rem3;
  logic [4:0]           hours_ones;
  logic [5:0]           minutes_ones;
  logic [3:0]           d0;
  logic [3:0]           d1;
  logic [3:0]           d2;
  logic [3:0]           d3;
  logic                 blank0;
  logic                 blank1;
  logic                 blank2;

  // Take the next command only when the display word has gone or is going
  assign pop = ~q_stat.empty & (~disp_valid | ~disp_stall);

  assign digit0_segments = digits[0];
  assign digit1_segments = digits[1];
  assign digit2_segments = digits[2];
  assign digit3_segments = digits[3];

  always_comb begin
    // Remainders from the quotients held in the queue
    rem1 = head.q100 - 7'(head.q1000) * 7'(DecBase);
    rem2 = head.q10 - 10'(head.q100) * 10'(DecBase);
    rem3 = head.value[13:0] - 14'(head.q10) * 14'(DecBase);
    hours_ones   = head.hours - 5'(head.hours_tens) * 5'(DecBase);
    minutes_ones = head.minutes - 6'(head.minutes_tens) * 6'(DecBase);
    d0 = head.q1000;
    d1 = rem1[3:0];
    d2 = rem2[3:0];
    d3 = rem3[3:0];
    blank0 = (d0 == '0);
    blank1 = blank0 & (d1 == '0);
    blank2 = blank1 & (d2 == '0);

    for (int i = 0; i < NumDigits; i++) begin
      digits_next[i] = digits[i];
    end
    points_next = points;
    colon_next  = colon;

    if (!head.bad) begin
      unique case (head.op)
        OP_SET_DIGIT:   digits_next[head.pos] = hex_seg(head.value[3:0]);
        OP_BLANK_DIGIT: digits_next[head.pos] = '0;
        OP_SET_POINT:   points_next = points | (3'b001 << head.pos);
        OP_CLR_POINT:   points_next = points & ~(3'b001 << head.pos);
        OP_SET_COLON:   colon_next = 1'b1;
        OP_CLR_COLON:   colon_next = 1'b0;
        OP_HEX: begin
          digits_next[0] = hex_seg(head.value[15:12]);
          digits_next[1] = hex_seg(head.value[11:8]);
          digits_next[2] = hex_seg(head.value[7:4]);
          digits_next[3] = hex_seg(head.value[3:0]);
        end
        OP_DECIMAL: begin
          digits_next[0] = blank0 ? '0 : hex_seg(d0);
          digits_next[1] = blank1 ? '0 : hex_seg(d1);
          digits_next[2] = blank2 ? '0 : hex_seg(d2);
          digits_next[3] = hex_seg(d3);
        end
        OP_TIME: begin
          digits_next[0] = hex_seg(4'(head.hours_tens));
          digits_next[1] = hex_seg(hours_ones[3:0]);
          digits_next[2] = hex_seg(4'(head.minutes_tens));
          digits_next[3] = hex_seg(minutes_ones[3:0]);
          colon_next     = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_valid <= 1'b0;
      points     <= '0;
      colon      <= 1'b0;
      for (int i = 0; i < NumDigits; i++) begin
        digits[i] <= '0;
      end
    end else if (pop) begin
      disp_valid <= 1'b1;
      points     <= points_next;
      colon      <= colon_next;
      for (int i = 0; i < NumDigits; i++) begin
        digits[i] <= digits_next[i];
      end
    end else if (!disp_stall) begin
      disp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bad_request <= head.bad;
    end
  end

endmodule

/* hw/rtl/four_digit_segment_display_control_core.sv */
`timescale 1ns / 1ps
// Channel    Handshake               Word
// command    cmd_valid / cmd_stall   op, position, value, hours, minutes
// display    disp_valid / disp_stall digit0..3_segments, points, colon, bad_request
//
// One command is taken every cycle while cmd_stall is low; it passes front, queue and back.
// The front stage classifies the command and forms the divide-by-1000/100/10 quotients;
// the back stage forms remainders, looks up segments and updates state.
// A two-word queue between them lets each side stall on its own: cmd_stall rises
// only when the front register is full and the queue holds two commands.
// Reset (synchronous, rst high) blanks all digits, clears points and colon, empties the pipe.
`include "four_digit_segment_display_control_core_assert.svh"
module four_digit_segment_display_control_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [3:0]  op,
  input  logic [1:0]  position,
  input  logic [15:0] value,
  input  logic [4:0]  hours,
  input  logic [5:0]  minutes,
  output logic        disp_valid,
  input  logic        disp_stall,
  output logic [6:0]  digit0_segments,
  output logic [6:0]  digit1_segments,
  output logic [6:0]  digit2_segments,
  output logic [6:0]  digit3_segments,
  output logic [2:0]  points,
  output logic        colon,
  output logic        bad_request
);
  import fdsd_pkg::*;

  logic        push;
  logic        pop;
  cmd_t        push_cmd;
  cmd_t        head;
  q_stat_t     q_stat;
  logic [31:0] disp_state;
  logic        point_op;

  // Front: take the command, flag bad requests, form quotients
  fdsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .op        (op),
    .position  (position),
    .value     (value),
    .hours     (hours),
    .minutes   (minutes),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Hold classified commands until the back end is free
  fdsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Back: apply the command to the display state and present the word
  fdsd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .disp_valid      (disp_valid),
    .disp_stall      (disp_stall),
    .digit0_segments (digit0_segments),
    .digit1_segments (digit1_segments),
    .digit2_segments (digit2_segments),
    .digit3_segments (digit3_segments),
    .points          (points),
    .colon           (colon),
    .bad_request     (bad_request)
  );

  // Gather the whole display state for the checks below
  assign disp_state = {digit0_segments, digit1_segments, digit2_segments, digit3_segments,
                       points, colon};
  assign point_op   = (head.op == OP_SET_POINT) || (head.op == OP_CLR_POINT);

  // A refused command leaves the display untouched
  `FDSD_ASSERT_NEXT(a_bad_keeps_display, pop && head.bad, $stable(disp_state))
  // A valid time always lights the colon
  `FDSD_ASSERT_NEXT(a_time_lights_colon, pop && !head.bad && head.op == OP_TIME, colon)
  // Points move only on point commands
  `FDSD_ASSERT_NEXT(a_points_only_on_point_ops, pop && !point_op, $stable(points))
  // Never overwrite a display word that is still stalled
  `FDSD_ASSERT_SAME(a_pop_needs_free_output, pop && disp_valid, !disp_stall)

endmodule

/* verif/four_digit_segment_display_control_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the four-digit segment display core.
// An initial block queues command words and a negedge driver feeds them to the
// block. A posedge monitor folds every accepted command into a model of the
// display and checks each returned display word against the oldest one awaited.
module four_digit_segment_display_control_core_tb;
  import fdsd_pkg::*;

  localparam int RandomPerPhase = 270;
  localparam int DrainCycles    = 8;     // front register, queue and back stage; leave some slack
  localparam int WatchdogLimit  = 2000;  // cycles with no word moving on either side

  // Segment font, index 0 first: bit0 is segment a, bit6 segment g
  localparam logic [0:15][6:0] Glyphs = {
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
  };

  typedef struct {
    logic [3:0]  op;
    logic [1:0]  pos;
    logic [15:0] value;
    logic [4:0]  hours;
    logic [5:0]  minutes;
  } cmd_word_t;

  typedef struct {
    seg_t       d0;
    seg_t       d1;
    seg_t       d2;
    seg_t       d3;
    logic [2:0] points;
    logic       colon;
    logic       bad;
  } display_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  logic [3:0]  op = '0;
  logic [1:0]  position = '0;
  logic [15:0] value = '0;
  logic [4:0]  hours = '0;
  logic [5:0]  minutes = '0;
  logic        disp_valid;
  logic        disp_stall = 1'b0;
  logic [6:0]  digit0_segments;
  logic [6:0]  digit1_segments;
  logic [6:0]  digit2_segments;
  logic [6:0]  digit3_segments;
  logic [2:0]  points;
  logic        colon;
  logic        bad_request;

  four_digit_segment_display_control_core dut (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_stall       (cmd_stall),
    .op              (op),
    .position        (position),
    .value           (value),
    .hours           (hours),
    .minutes         (minutes),
    .disp_valid      (disp_valid),
    .disp_stall      (disp_stall),
    .digit0_segments (digit0_segments),
    .digit1_segments (digit1_segments),
    .digit2_segments (digit2_segments),
    .digit3_segments (digit3_segments),
    .points          (points),
    .colon           (colon),
    .bad_request     (bad_request)
  );

  cmd_word_t     pending_cmds [$];
  display_word_t awaited_displays [$];

  // Model of what the display holds
  seg_t       shown_glyphs [4];
  logic [2:0] lit_points;
  logic       lit_colon;

  int  tx_idle_pct = 31;
  int  rx_idle_pct = 56;
  int  cmds_issued = 0;
  int  results_checked = 0;
  int  failures = 0;
  int  quiet_cycles = 0;
  bit  cmd_taken = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one command to the display model and return the word it should produce.
  task automatic next_display(input cmd_word_t c, output display_word_t d);
    int  dec [4];
    bit  leading;
    int  i;
    d.bad = 1'b0;
    case (c.op)
      OP_SET_DIGIT: begin
        // a digit write leaves the points and colon alone
        if (c.value > MaxHexDigit) d.bad = 1'b1;
        else shown_glyphs[c.pos] = Glyphs[c.value[3:0]];
      end
      OP_BLANK_DIGIT: shown_glyphs[c.pos] = '0;
      OP_SET_POINT: begin
        if (c.pos > 2'd2) d.bad = 1'b1;
        else lit_points[c.pos] = 1'b1;
      end
      OP_CLR_POINT: begin
        if (c.pos > 2'd2) d.bad = 1'b1;
        else lit_points[c.pos] = 1'b0;
      end
      OP_SET_COLON: lit_colon = 1'b1;
      OP_CLR_COLON: lit_colon = 1'b0;
      OP_HEX: begin
        for (i = 0; i < NumDigits; i++) shown_glyphs[i] = Glyphs[c.value[4*(3-i) +: 4]];
      end
      OP_DECIMAL: begin
        if (c.value > MaxDecimal) begin
          d.bad = 1'b1;
        end else begin
          dec[0] = c.value / 1000;
          dec[1] = (c.value / 100) % DecBase;
          dec[2] = (c.value / DecBase) % DecBase;
          dec[3] = c.value % DecBase;
          // blank leading zeros, but the units digit always shows
          leading = 1'b1;
          for (i = 0; i < 3; i++) begin
            if (leading && dec[i] == 0) begin
              shown_glyphs[i] = '0;
            end else begin
              leading = 1'b0;
              shown_glyphs[i] = Glyphs[dec[i]];
            end
          end
          shown_glyphs[3] = Glyphs[dec[3]];
        end
      end
      OP_TIME: begin
        if (c.hours > MaxHours || c.minutes > MaxMinutes) begin
          d.bad = 1'b1;
        end else begin
          // all four digits show, colon lights, points hold
          shown_glyphs[0] = Glyphs[c.hours / DecBase];
          shown_glyphs[1] = Glyphs[c.hours % DecBase];
          shown_glyphs[2] = Glyphs[c.minutes / DecBase];
          shown_glyphs[3] = Glyphs[c.minutes % DecBase];
          lit_colon = 1'b1;
        end
      end
      default: d.bad = 1'b1;
    endcase
    d.d0     = shown_glyphs[0];
    d.d1     = shown_glyphs[1];
    d.d2     = shown_glyphs[2];
    d.d3     = shown_glyphs[3];
    d.points = lit_points;
    d.colon  = lit_colon;
  endtask

  task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      failures++;
    end
  endtask

  task automatic queue_cmd(input logic [3:0] c_op, input logic [1:0] c_pos,
                           input logic [15:0] c_value, input logic [4:0] c_hours,
                           input logic [5:0] c_minutes);
    cmd_word_t c;
    c.op      = c_op;
    c.pos     = c_pos;
    c.value   = c_value;
    c.hours   = c_hours;
    c.minutes = c_minutes;
    pending_cmds.push_back(c);
    cmds_issued++;
  endtask

  // Mostly well-formed commands with random content; a share of out-of-range
  // requests and some pure noise, which is where the unknown ops come from.
  function automatic cmd_word_t random_cmd();
    cmd_word_t c;
    int        pick;
    int        span;
    c.op      = 4'($urandom_range(0, 8));
    c.pos     = 2'($urandom);
    c.value   = 16'($urandom);
    c.hours   = 5'($urandom);
    c.minutes = 6'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      c.op = 4'($urandom);
      return c;
    end
    case (c.op)
      OP_SET_DIGIT: begin
        if (pick < 85) c.value = 16'($urandom_range(0, MaxHexDigit));
      end
      OP_DECIMAL: begin
        // spread over one to four digits so leading-zero blanking gets exercised
        if (pick < 85) begin
          span    = $urandom_range(1, 4);
          c.value = 16'($urandom_range(0, (10 ** span) - 1));
        end
      end
      OP_TIME: begin
        if (pick < 85) begin
          c.hours   = 5'($urandom_range(0, MaxHours));
          c.minutes = 6'($urandom_range(0, MaxMinutes));
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  // Driver: change inputs on the falling edge. Hold a word until it is taken,
  // then either present the next one or idle.
  always @(negedge clk) begin
    cmd_word_t c;
    if (rst) begin
      cmd_valid  <= 1'b0;
      disp_stall <= 1'b0;
    end else begin
      disp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      if (!cmd_valid || cmd_taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          c = pending_cmds.pop_front();
          cmd_valid <= 1'b1;
          op        <= c.op;
          position  <= c.pos;
          value     <= c.value;
          hours     <= c.hours;
          minutes   <= c.minutes;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: on each rising edge record an accepted command word into the
  // model first, then check any display word the block hands over.
  always @(posedge clk) begin
    cmd_word_t     c;
    display_word_t want;
    if (rst) begin
      cmd_taken <= 1'b0;
      for (int i = 0; i < NumDigits; i++) shown_glyphs[i] = '0;
      lit_points = '0;
      lit_colon  = 1'b0;
    end else begin
      cmd_taken <= cmd_valid && !cmd_stall;
      if (cmd_valid && !cmd_stall) begin
        c.op      = op;
        c.pos     = position;
        c.value   = value;
        c.hours   = hours;
        c.minutes = minutes;
        next_display(c, want);
        awaited_displays.push_back(want);
      end
      if (disp_valid && !disp_stall) begin
        if (awaited_displays.size() == 0) begin
          $error("display word arrived with no command waiting for it");
          failures++;
        end else begin
          want = awaited_displays.pop_front();
          check_field("digit0_segments", want.d0, digit0_segments);
          check_field("digit1_segments", want.d1, digit1_segments);
          check_field("digit2_segments", want.d2, digit2_segments);
          check_field("digit3_segments", want.d3, digit3_segments);
          check_field("points", 7'(want.points), 7'(points));
          check_field("colon", 7'(want.colon), 7'(colon));
          check_field("bad_request", 7'(want.bad), 7'(bad_request));
          results_checked <= results_checked + 1;
        end
      end
    end
  end

  // Watchdog: give up if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (disp_valid && !disp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int        phase;
    cmd_word_t c;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every op and every refusal case
    queue_cmd(OP_SET_DIGIT, 2'd0, 16'h0000, 5'd0, 6'd0);
    queue_cmd(OP_SET_DIGIT, 2'd1, 16'h000F, 5'd31, 6'd63);
    queue_cmd(OP_SET_DIGIT, 2'd2, 16'h0010, 5'd0, 6'd0);    // digit value too large
    queue_cmd(OP_SET_DIGIT, 2'd3, 16'hFFFF, 5'd31, 6'd63);
    queue_cmd(OP_SET_POINT, 2'd0, 16'hFFFF, 5'd0, 6'd0);
    queue_cmd(OP_SET_POINT, 2'd2, 16'h0000, 5'd0, 6'd0);
    queue_cmd(OP_SET_POINT, 2'd3, 16'h0000, 5'd0, 6'd0);    // no fourth point
    queue_cmd(OP_CLR_POINT, 2'd3, 16'h0000, 5'd0, 6'd0);
    queue_cmd(OP_CLR_POINT, 2'd0, 16'h0000, 5'd0, 6'd0);
    queue_cmd(OP_SET_COLON, 2'd3, 16'hFFFF, 5'd31, 6'd63);
    queue_cmd(OP_SET_DIGIT, 2'd2, 16'h0005, 5'd0, 6'd0);    // point and colon must survive
    queue_cmd(OP_CLR_COLON, 2'd0, 16'h0000, 5'd0, 6'd0);
    queue_cmd(OP_BLANK_DIGIT, 2'd3, 16'hFFFF, 5'd0, 6'd0);
    queue_cmd(OP_BLANK_DIGIT, 2'd0, 16'h0000, 5'd0, 6'd0);
    queue_cmd(OP_HEX, 2'd0, 16'hFFFF, 5'd0, 6'd0);
    queue_cmd(OP_HEX, 2'd1, 16'hA5C3, 5'd0, 6'd0);
    queue_cmd(OP_DECIMAL, 2'd0, 16'd0, 5'd0, 6'd0);        // a lone zero
    queue_cmd(OP_DECIMAL, 2'd0, 16'd105, 5'd0, 6'd0);      // inner zero kept
    queue_cmd(OP_DECIMAL, 2'd0, 16'd9999, 5'd0, 6'd0);
    queue_cmd(OP_DECIMAL, 2'd0, 16'd10000, 5'd0, 6'd0);    // one past the top
    queue_cmd(OP_TIME, 2'd0, 16'h0000, 5'd23, 6'd59);
    queue_cmd(OP_TIME, 2'd0, 16'h0000, 5'd0, 6'd0);
    queue_cmd(OP_TIME, 2'd0, 16'h0000, 5'd24, 6'd0);       // hours out of range
    queue_cmd(OP_TIME, 2'd0, 16'h0000, 5'd12, 6'd60);      // minutes out of range
    queue_cmd(4'd9, 2'd0, 16'h0000, 5'd0, 6'd0);
    queue_cmd(4'd15, 2'd3, 16'hFFFF, 5'd31, 6'd63);

    // Random phases: sender mostly busy, then receiver mostly busy, then no idling
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 31; rx_idle_pct = 56; end
        1: begin tx_idle_pct = 56; rx_idle_pct = 31; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      repeat (RandomPerPhase) begin
        c = random_cmd();
        queue_cmd(c.op, c.pos, c.value, c.hours, c.minutes);
      end
      // hold new commands back until every display word has come home
      while (results_checked != cmds_issued) @(posedge clk);
    end

    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
